// ----- rtl/core/tcw_pkg.sv -----
// Shared constants, operation codes and control types for the text console writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // Default geometry of the screen and of the edit line.
    localparam int unsigned COLUMNS_DEFAULT  = 80;
    localparam int unsigned CELLS_DEFAULT    = 2000;
    localparam int unsigned LINE_MAX_DEFAULT = 63;

    // Cell contents and key codes.
    localparam logic [15:0] BLANK_CELL       = 16'h0720;
    localparam logic [7:0]  CHAR_SPACE       = 8'h20;
    localparam logic [7:0]  KEY_ENTER        = 8'h0D;
    localparam logic [7:0]  KEY_BACKSPACE    = 8'h08;
    localparam logic [7:0]  TEXT_COLOR_RESET = 8'h07;

    // Configuration register word index.
    localparam logic REG_TEXT_COLOR = 1'b0;

    // Operation codes carried by the opcode field.
    typedef enum logic [2:0] {
        OP_KEY     = 3'd0,
        OP_PRINT   = 3'd1,
        OP_NEWLINE = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_READ    = 3'd4
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the input word
        logic exec;   // carry out the captured operation
        logic sweep;  // write one blank cell of the clearing pass
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_clear;    // captured operation is a clear
        logic sweep_last;  // clearing pass is at its last cell
    } ctl_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/tcw_ctrl.sv -----
// Controller state machine that sequences accept, execute, clear sweep and result.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire tcw_pkg::ctl_status_t status,
    output tcw_pkg::ctl_cmd_t        cmd,
    output logic                     busy,
    output logic                     done
);

    typedef enum logic [4:0] {
        ST_INIT  = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_EXEC  = 5'b00100,
        ST_SWEEP = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.op_clear ? ST_SWEEP : ST_RESP;
            end
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register; reset starts the clearing pass over the screen.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A new word is taken while idle or while the previous result is shown.
    assign busy = !((state_reg == ST_IDLE) || (state_reg == ST_RESP));
    assign done = (state_reg == ST_RESP);

endmodule

`default_nettype wire

// ----- rtl/core/tcw_datapath.sv -----
// Datapath with the screen memory, cursor, column and edit line registers.
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath #(
    parameter int unsigned COLUMNS  = tcw_pkg::COLUMNS_DEFAULT,
    parameter int unsigned CELLS    = tcw_pkg::CELLS_DEFAULT,
    parameter int unsigned LINE_MAX = tcw_pkg::LINE_MAX_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tcw_pkg::ctl_cmd_t             cmd,
    output tcw_pkg::ctl_status_t               status,
    input  wire logic [7:0]                    text_color,
    input  wire logic [2:0]                    opcode,
    input  wire logic [7:0]                    char_code,
    input  wire logic [$clog2(CELLS)-1:0]      cell_index,
    output logic      [$clog2(CELLS+1)-1:0]    cursor_position,
    output logic      [$clog2(LINE_MAX+1)-1:0] line_length,
    output logic                               line_done,
    output logic      [7:0]                    read_char,
    output logic      [7:0]                    read_attr
);

    localparam int unsigned AW    = $clog2(CELLS);
    localparam int unsigned CUR_W = $clog2(CELLS + 1);
    localparam int unsigned LW    = $clog2(LINE_MAX + 1);
    localparam int unsigned COL_W = $clog2(COLUMNS);
    localparam int unsigned NL_W  = $clog2(CELLS + COLUMNS + 1);

    localparam logic [CUR_W-1:0] CELLS_CUR  = CUR_W'(CELLS);
    localparam logic [AW:0]      CELLS_IDX  = (AW + 1)'(CELLS);
    localparam logic [AW-1:0]    LAST_CELL  = AW'(CELLS - 1);
    localparam logic [NL_W-1:0]  CELLS_NL   = NL_W'(CELLS);
    localparam logic [NL_W-1:0]  COLUMNS_NL = NL_W'(COLUMNS);
    localparam logic [COL_W-1:0] COL_END    = COL_W'(COLUMNS - 1);
    localparam logic [COL_W-1:0] COL_SAT    = COL_W'(CELLS % COLUMNS);
    localparam logic [LW-1:0]    LINE_LIMIT = LW'(LINE_MAX);

    // Captured input word.
    logic [2:0]       op_reg;
    logic [7:0]       ch_reg;
    logic [AW-1:0]    idx_reg;

    // Console state; col_reg tracks the cursor modulo the row width.
    logic [CUR_W-1:0] cursor_reg, cursor_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [LW-1:0]    edit_reg, edit_next;
    logic [AW-1:0]    clear_cnt_reg, clear_cnt_next;
    logic             line_done_reg, line_done_next;
    logic             rd_valid_reg, rd_valid_next;

    // Screen memory ports.
    logic [15:0]      mem [CELLS];
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [15:0]      wr_data;
    logic             rd_en;
    logic [15:0]      rdata_reg;

    // Helper values for cursor moves.
    logic             cur_on_screen;
    logic [CUR_W-1:0] cur_inc;
    logic [CUR_W-1:0] cur_dec;
    logic [COL_W-1:0] col_inc;
    logic [COL_W-1:0] col_dec;
    logic [NL_W-1:0]  nl_target;
    logic             idx_on_screen;

    assign cur_on_screen = (cursor_reg < CELLS_CUR);
    assign cur_inc       = cursor_reg + CUR_W'(1);
    assign cur_dec       = cursor_reg - CUR_W'(1);
    assign col_inc       = (col_reg == COL_END) ? '0 : col_reg + COL_W'(1);
    assign col_dec       = (col_reg == '0) ? COL_END : col_reg - COL_W'(1);
    assign nl_target     = NL_W'(cursor_reg) - NL_W'(col_reg) + COLUMNS_NL;
    assign idx_on_screen = ({1'b0, idx_reg} < CELLS_IDX);

    assign status.op_clear   = (op_reg == tcw_pkg::OP_CLEAR);
    assign status.sweep_last = (clear_cnt_reg == LAST_CELL);

    // Operation decode and next state of the console.
    always_comb
    begin
        cursor_next    = cursor_reg;
        col_next       = col_reg;
        edit_next      = edit_reg;
        clear_cnt_next = clear_cnt_reg;
        line_done_next = line_done_reg;
        rd_valid_next  = rd_valid_reg;
        wr_en          = 1'b0;
        wr_addr        = cursor_reg[AW-1:0];
        wr_data        = {text_color, ch_reg};
        rd_en          = 1'b0;

        if (cmd.load)
        begin
            line_done_next = 1'b0;
            rd_valid_next  = 1'b0;
        end

        // One blank cell per cycle of the clearing pass.
        if (cmd.sweep)
        begin
            wr_en          = 1'b1;
            wr_addr        = clear_cnt_reg;
            wr_data        = tcw_pkg::BLANK_CELL;
            cursor_next    = '0;
            col_next       = '0;
            clear_cnt_next = status.sweep_last ? '0 : clear_cnt_reg + AW'(1);
        end

        if (cmd.exec)
        begin
            case (op_reg)
                tcw_pkg::OP_KEY:
                begin
                    if (ch_reg == tcw_pkg::KEY_ENTER)
                    begin
                        edit_next      = '0;
                        line_done_next = 1'b1;
                        if (nl_target >= CELLS_NL)
                        begin
                            cursor_next = CELLS_CUR;
                            col_next    = COL_SAT;
                        end
                        else
                        begin
                            cursor_next = CUR_W'(nl_target);
                            col_next    = '0;
                        end
                    end
                    else if (ch_reg == tcw_pkg::KEY_BACKSPACE)
                    begin
                        if (edit_reg != '0)
                        begin
                            edit_next = edit_reg - LW'(1);
                            if (cursor_reg != '0)
                            begin
                                cursor_next = cur_dec;
                                col_next    = col_dec;
                                wr_en       = 1'b1;
                                wr_addr     = cur_dec[AW-1:0];
                                wr_data     = {text_color, tcw_pkg::CHAR_SPACE};
                            end
                        end
                    end
                    else if (edit_reg < LINE_LIMIT)
                    begin
                        edit_next = edit_reg + LW'(1);
                        if (cur_on_screen)
                        begin
                            wr_en       = 1'b1;
                            cursor_next = cur_inc;
                            col_next    = col_inc;
                        end
                    end
                end
                tcw_pkg::OP_PRINT:
                begin
                    if (cur_on_screen)
                    begin
                        wr_en       = 1'b1;
                        cursor_next = cur_inc;
                        col_next    = col_inc;
                    end
                end
                tcw_pkg::OP_NEWLINE:
                begin
                    if (nl_target >= CELLS_NL)
                    begin
                        cursor_next = CELLS_CUR;
                        col_next    = COL_SAT;
                    end
                    else
                    begin
                        cursor_next = CUR_W'(nl_target);
                        col_next    = '0;
                    end
                end
                tcw_pkg::OP_READ:
                begin
                    rd_en         = idx_on_screen;
                    rd_valid_next = idx_on_screen;
                end
                default:
                begin
                    // Clear runs as a sweep; unused codes change nothing.
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            col_reg       <= '0;
            edit_reg      <= '0;
            clear_cnt_reg <= '0;
            line_done_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            edit_reg      <= edit_next;
            clear_cnt_reg <= clear_cnt_next;
            line_done_reg <= line_done_next;
            rd_valid_reg  <= rd_valid_next;
        end
    end

    // Input word capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            ch_reg  <= char_code;
            idx_reg <= cell_index;
        end
    end

    // Screen memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[idx_reg];
        end
    end

    // Result fields.
    assign cursor_position = cursor_reg;
    assign line_length     = edit_reg;
    assign line_done       = line_done_reg;
    assign read_char       = rd_valid_reg ? rdata_reg[7:0]  : 8'h00;
    assign read_attr       = rd_valid_reg ? rdata_reg[15:8] : 8'h00;

endmodule

`default_nettype wire

// ----- rtl/core/text_console_writer.sv -----
// Top level of the text console writer: configuration register, controller and datapath.
//
//   Channel   Signals                                   Direction  Handshake
//   command   start, opcode, char_code, cell_index      in         start && !busy
//   result    done, cursor_position, line_length,       out        done, one cycle
//             line_done, read_char, read_attr
//   config    psel, penable, pwrite, paddr, pwdata,     in/out     APB, pready high
//             prdata, pready
//
// A word executes against the screen memory in the EXEC state and shows its result in
// the RESP state, during which the next word is already accepted.
// Clear walks the memory one cell per cycle in the SWEEP state, then shows its result.
// After reset the same clearing pass runs with busy high.
// The receiver cannot stall; done is high for exactly one cycle per word.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer #(
    parameter int unsigned COLUMNS  = tcw_pkg::COLUMNS_DEFAULT,
    parameter int unsigned CELLS    = tcw_pkg::CELLS_DEFAULT,
    parameter int unsigned LINE_MAX = tcw_pkg::LINE_MAX_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Command and result
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [2:0]                    opcode,
    input  wire logic [7:0]                    char_code,
    input  wire logic [$clog2(CELLS)-1:0]      cell_index,
    output logic                               done,
    output logic      [$clog2(CELLS+1)-1:0]    cursor_position,
    output logic      [$clog2(LINE_MAX+1)-1:0] line_length,
    output logic                               line_done,
    output logic      [7:0]                    read_char,
    output logic      [7:0]                    read_attr,
    // Configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);

    tcw_pkg::ctl_cmd_t    cmd;
    tcw_pkg::ctl_status_t status;

    logic [7:0] text_color_reg;
    logic       reg_sel;

    // Byte address bit 2 selects the register word.
    assign reg_sel = (paddr[2] == tcw_pkg::REG_TEXT_COLOR);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {24'h000000, text_color_reg} : 32'h00000000;

    // Text color register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= tcw_pkg::TEXT_COLOR_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            text_color_reg <= pwdata[7:0];
        end
    end

    // Controller.
    tcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Datapath.
    tcw_datapath #(
        .COLUMNS  (COLUMNS),
        .CELLS    (CELLS),
        .LINE_MAX (LINE_MAX)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .text_color      (text_color_reg),
        .opcode          (opcode),
        .char_code       (char_code),
        .cell_index      (cell_index),
        .cursor_position (cursor_position),
        .line_length     (line_length),
        .line_done       (line_done),
        .read_char       (read_char),
        .read_attr       (read_attr)
    );

endmodule

`default_nettype wire

// ----- rtl/core/tcw_checker.sv -----
// Port-level checker for the text console writer and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module tcw_checker #(
    parameter int unsigned LEN_W = 6
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             done,
    input wire logic [LEN_W-1:0] line_length,
    input wire logic             line_done,
    input wire logic [7:0]       read_char,
    input wire logic [7:0]       read_attr
);

    // An accepted word keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make the block busy");

    // A result is shown while a new word may be taken.
    a_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // Each word gives a single one-cycle strobe.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    // An ended edit line leaves an empty line.
    a_enter_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && line_done) |-> (line_length == '0))
        else $error("line ended but length is not zero");

    // Enter is no read, so no cell contents appear with it.
    a_enter_noread: assert property (@(posedge clk) disable iff (!rst_n)
        (done && line_done) |-> ((read_char == 8'h00) && (read_attr == 8'h00)))
        else $error("read fields set on an enter result");

endmodule

bind text_console_writer tcw_checker #(
    .LEN_W ($clog2(LINE_MAX + 1))
) u_tcw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .line_length (line_length),
    .line_done   (line_done),
    .read_char   (read_char),
    .read_attr   (read_attr)
);

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the text console writer with a screen model and color register.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned COLUMNS     = tcw_pkg::COLUMNS_DEFAULT;
    localparam int unsigned CELLS       = tcw_pkg::CELLS_DEFAULT;
    localparam int unsigned LINE_MAX    = tcw_pkg::LINE_MAX_DEFAULT;
    localparam int unsigned CYCLE_LIMIT = 6_000_000;
    localparam int unsigned MAX_REPORTS = 10;

    // Opcodes outside the defined set; the block must leave its state alone.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  ch;
        logic [10:0] idx;
    } console_word_t;

    typedef struct packed {
        logic [10:0] cursor;
        logic [5:0]  length;
        logic        line_done;
        logic [7:0]  rchar;
        logic [7:0]  rattr;
    } console_status_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  opcode;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
    logic        done;
    logic [10:0] cursor_position;
    logic [5:0]  line_length;
    logic        line_done;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Screen model and console state as the block should hold them.
    logic [15:0]  screen_model [0:CELLS-1];
    int unsigned  cursor_model;
    int unsigned  line_model;
    logic [7:0]   color_model;

    console_word_t   word_queue[$];
    console_status_t status_queue[$];

    int unsigned idle_pct;
    int unsigned words_queued;
    int unsigned words_planned;
    int unsigned words_accepted;
    int unsigned results_seen;
    int unsigned error_count;
    int unsigned cycle_count;
    logic        word_taken;

    text_console_writer u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .char_code       (char_code),
        .cell_index      (cell_index),
        .done            (done),
        .cursor_position (cursor_position),
        .line_length     (line_length),
        .line_done       (line_done),
        .read_char       (read_char),
        .read_attr       (read_attr),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Free-running clock with a 4 ns period.
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Report a field that differs from the prediction.
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("Mismatch on %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Write a character with the current color at the cursor, dropped at the screen end.
    task automatic put_char(input logic [7:0] ch);
        if (cursor_model < CELLS)
        begin
            screen_model[cursor_model] = {color_model, ch};
            cursor_model++;
        end
    endtask

    // Move the cursor to the start of the next row, saturated at the screen end.
    task automatic advance_line();
        int unsigned next_row;
        next_row = (cursor_model / COLUMNS + 1) * COLUMNS;
        cursor_model = (next_row > CELLS) ? CELLS : next_row;
    endtask

    task automatic blank_screen();
        for (int i = 0; i < CELLS; i++)
            screen_model[i] = tcw_pkg::BLANK_CELL;
        cursor_model = 0;
    endtask

    // Apply one accepted word to the model and queue the status it should produce.
    task automatic console_step(input console_word_t w);
        console_status_t st;
        st = '0;
        case (w.op)
            tcw_pkg::OP_KEY:
            begin
                if (w.ch == tcw_pkg::KEY_ENTER)
                begin
                    line_model = 0;
                    st.line_done = 1'b1;
                    advance_line();
                end
                else if (w.ch == tcw_pkg::KEY_BACKSPACE)
                begin
                    if (line_model != 0)
                    begin
                        line_model--;
                        if (cursor_model != 0)
                        begin
                            cursor_model--;
                            screen_model[cursor_model] = {color_model, tcw_pkg::CHAR_SPACE};
                        end
                    end
                end
                else if (line_model < LINE_MAX)
                begin
                    put_char(w.ch);
                    line_model++;
                end
            end
            tcw_pkg::OP_PRINT:   put_char(w.ch);
            tcw_pkg::OP_NEWLINE: advance_line();
            tcw_pkg::OP_CLEAR:   blank_screen();
            tcw_pkg::OP_READ:
            begin
                if (w.idx < CELLS)
                begin
                    st.rchar = screen_model[w.idx][7:0];
                    st.rattr = screen_model[w.idx][15:8];
                end
            end
            default: ;
        endcase
        st.cursor = cursor_model[10:0];
        st.length = line_model[5:0];
        status_queue.push_back(st);
    endtask

    // Monitor: check each result word against the oldest prediction, then predict accepted words.
    always @(posedge clk)
    begin : monitor
        console_status_t want;
        if (!rst_n)
            word_taken <= 1'b0;
        else
        begin
            if (done)
            begin
                results_seen++;
                if (status_queue.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("Result word with no command outstanding");
                end
                else
                begin
                    want = status_queue.pop_front();
                    check_field("cursor_position", 32'(want.cursor), 32'(cursor_position));
                    check_field("line_length", 32'(want.length), 32'(line_length));
                    check_field("line_done", 32'(want.line_done), 32'(line_done));
                    check_field("read_char", 32'(want.rchar), 32'(read_char));
                    check_field("read_attr", 32'(want.rattr), 32'(read_attr));
                end
            end
            if (start && !busy)
            begin
                words_accepted++;
                console_step('{op: opcode, ch: char_code, idx: cell_index});
            end
            word_taken <= start && !busy;
        end
    end

    // Driver: present the next command word at the falling edge, with random gaps.
    always @(negedge clk)
    begin : driver
        console_word_t w;
        if (rst_n && (!start || word_taken))
        begin
            if (word_queue.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                w = word_queue.pop_front();
                opcode     <= w.op;
                char_code  <= w.ch;
                cell_index <= w.idx;
                start      <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic add_word(input logic [2:0] op, input logic [7:0] ch, input logic [10:0] idx);
        word_queue.push_back('{op: op, ch: ch, idx: idx});
        words_queued++;
        if (op <= tcw_pkg::OP_READ)
            words_planned++;
    endtask

    // Wait until every queued word has been taken and answered and the block is idle.
    task automatic wait_idle();
        @(negedge clk);
        while (words_accepted != words_queued || results_seen != words_accepted || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write the color register over APB, then read it back.
    task automatic write_color(input logic [7:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'(tcw_pkg::REG_TEXT_COLOR) << 2;
        pwdata  <= {24'h0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        color_model = value;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("text_color readback", 32'(value), 32'(prdata[7:0]));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [10:0] pick_cell();
        if ($urandom_range(3) == 0)
            return 11'($urandom_range(2047));
        return 11'($urandom_range(479));
    endfunction

    // Random traffic: mostly edit lines and console output, with some noise.
    task automatic add_random_words(input int unsigned count);
        int unsigned goal;
        int unsigned kind;
        int unsigned len;
        goal = words_planned + count;
        while (words_planned < goal)
        begin
            kind = $urandom_range(99);
            if (kind < 35)
            begin
                // Typed line with some backspaces; long lines run past the line limit.
                len = ($urandom_range(6) == 0) ? $urandom_range(60, 70)
                                               : $urandom_range(1, 15);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(99) < 15)
                        add_word(tcw_pkg::OP_KEY, tcw_pkg::KEY_BACKSPACE, 11'($urandom));
                    else
                        add_word(tcw_pkg::OP_KEY, 8'($urandom), 11'($urandom));
                end
                if ($urandom_range(99) < 80)
                    add_word(tcw_pkg::OP_KEY, tcw_pkg::KEY_ENTER, 11'($urandom));
            end
            else if (kind < 50)
            begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                    add_word(tcw_pkg::OP_PRINT, 8'($urandom), 11'($urandom));
            end
            else if (kind < 60)
            begin
                // Occasionally enough newlines to pin the cursor at the screen end.
                len = ($urandom_range(3) == 0) ? $urandom_range(26, 30) : $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                    add_word(tcw_pkg::OP_NEWLINE, 8'($urandom), 11'($urandom));
            end
            else if (kind < 75)
            begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    add_word(tcw_pkg::OP_READ, 8'($urandom), pick_cell());
            end
            else if (kind < 78)
                add_word(tcw_pkg::OP_CLEAR, 8'($urandom), 11'($urandom));
            else if (kind < 85)
            begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    add_word(tcw_pkg::OP_KEY, tcw_pkg::KEY_BACKSPACE, 11'($urandom));
            end
            else
                add_word(3'($urandom), 8'($urandom), 11'($urandom));
        end
    endtask

    // Run one phase: drain, set the color, then queue the words of the phase.
    task automatic run_phase(input logic [7:0] color, input int unsigned idle,
                             input int unsigned count);
        wait_idle();
        write_color(color);
        idle_pct = idle;
        @(posedge clk);
        add_random_words(count);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        opcode     = tcw_pkg::OP_KEY;
        char_code  = 8'h00;
        cell_index = 11'd0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = 3'd0;
        pwdata     = 32'h0;
        idle_pct       = 35;
        words_queued   = 0;
        words_planned  = 0;
        words_accepted = 0;
        results_seen   = 0;
        error_count    = 0;
        cycle_count    = 0;
        line_model     = 0;
        color_model    = tcw_pkg::TEXT_COLOR_RESET;
        blank_screen();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words at the brightest color.
        wait_idle();
        write_color(8'hFF);
        @(posedge clk);
        add_word(tcw_pkg::OP_READ, 8'h00, 11'd0);
        add_word(tcw_pkg::OP_READ, 8'hFF, 11'(CELLS - 1));
        add_word(tcw_pkg::OP_READ, 8'h00, 11'(CELLS));
        add_word(tcw_pkg::OP_READ, 8'h00, 11'h7FF);
        add_word(tcw_pkg::OP_PRINT, 8'h00, 11'd0);
        add_word(tcw_pkg::OP_PRINT, 8'hFF, 11'h7FF);
        add_word(tcw_pkg::OP_KEY, 8'h41, 11'd0);
        add_word(tcw_pkg::OP_KEY, 8'h00, 11'd0);
        add_word(tcw_pkg::OP_KEY, tcw_pkg::KEY_BACKSPACE, 11'd0);
        add_word(tcw_pkg::OP_KEY, tcw_pkg::KEY_ENTER, 11'd0);
        add_word(tcw_pkg::OP_NEWLINE, 8'h00, 11'd0);
        add_word(tcw_pkg::OP_KEY, tcw_pkg::KEY_BACKSPACE, 11'd0);
        add_word(tcw_pkg::OP_READ, 8'h00, 11'd1);
        // Backspace at cell zero with a pending line: clear keeps the line count.
        add_word(tcw_pkg::OP_KEY, 8'h78, 11'd0);
        add_word(tcw_pkg::OP_CLEAR, 8'h00, 11'd0);
        add_word(tcw_pkg::OP_KEY, tcw_pkg::KEY_BACKSPACE, 11'd0);
        add_word(tcw_pkg::OP_READ, 8'h00, 11'd0);
        add_word(tcw_pkg::OP_READ, 8'h00, 11'd80);
        add_word(OP_SPARE_FIRST, 8'hFF, 11'h7FF);
        add_word(OP_SPARE_LAST, 8'h00, 11'd0);

        run_phase(8'h00, 35, 120);
        run_phase(8'($urandom), 88, 200);
        run_phase(8'($urandom), 0, 150);
        run_phase(tcw_pkg::TEXT_COLOR_RESET, 0, 150);

        wait_idle();
        repeat (8) @(negedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
